/* rtl/pdz_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdz_pkg: shared types and constants
// Register map, control word layout and the words passed between the stages
// of the dead-zone position controller.
// ----------------------------------------------------------------------------
package pdz_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRAWL_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_SHIFT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ERROR     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_RATE      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_FORCE     = 3'd7;

   // 0.9 in Q15
   localparam logic [14:0] MAX_ERROR_RESET = 15'd29491;

   typedef struct packed {
      logic        [14:0] dead_zone;
      logic        [14:0] crawl_speed;
      logic signed [15:0] prop_gain;
      logic signed [15:0] diff_gain;
      logic        [4:0]  control_shift;
      logic        [14:0] max_error;
      logic               use_rate;
      logic               use_force;
   } cfg_type;

   // Per-word side fields carried down the pipeline
   typedef struct packed {
      logic signed [15:0] rate;
      logic signed [15:0] bias;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
   } side_type;

   // Shaped error leaving the error stages
   typedef struct packed {
      logic signed [15:0] err;
      logic               idle;
      side_type           side;
   } shaped_type;

   // Shifted and biased drive leaving the gain stages
   typedef struct packed {
      logic signed [33:0] value;
      logic               idle;
      logic               crawl_up;
      logic               crawl_dn;
      side_type           side;
   } drive_type;

endpackage
`default_nettype wire

/* rtl/pdz_error.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdz_error: position error and dead-zone shaping
// Stage A forms the full-width error; stage B applies dead zone and clamp.
// ----------------------------------------------------------------------------
module pdz_error (
   input  wire logic               clock,
   input  wire logic               en_a,
   input  wire logic               en_b,
   input  wire pdz_pkg::cfg_type   cfg,
   input  wire logic signed [31:0] target_pos,
   input  wire logic signed [31:0] measured_pos,
   input  wire pdz_pkg::side_type  side_in,
   output pdz_pkg::shaped_type     shaped
);
   import pdz_pkg::*;

   logic signed [32:0] err_ff, err_in;
   side_type           side_ff;
   shaped_type         shaped_ff, shaped_in;

   // Stage A: error at 33 bits, no wrap
   assign err_in = $signed({target_pos[31], target_pos}) -
                   $signed({measured_pos[31], measured_pos});

   always_ff @(posedge clock) begin
      if (en_a) begin
         err_ff  <= err_in;
         side_ff <= side_in;
      end
   end

   // Stage B: dead zone, clamp and dead-zone pull
   always_comb begin
      logic signed [32:0] dz_s;
      logic signed [32:0] me_s;
      logic signed [32:0] adj;
      logic               pos;
      logic               neg;
      dz_s = $signed({18'd0, cfg.dead_zone});
      me_s = $signed({18'd0, cfg.max_error});
      pos  = err_ff > dz_s;
      neg  = err_ff < -dz_s;
      adj  = err_ff;
      if (pos) begin
         if (err_ff > me_s) begin
            adj = me_s;
         end else if (cfg.crawl_speed == 15'd0) begin
            adj = err_ff - dz_s;
         end
      end else if (neg) begin
         if (err_ff < -me_s) begin
            adj = -me_s;
         end else if (cfg.crawl_speed == 15'd0) begin
            adj = err_ff + dz_s;
         end
      end
      shaped_in.err  = adj[15:0];
      shaped_in.idle = !pos && !neg;
      shaped_in.side = side_ff;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         shaped_ff <= shaped_in;
      end
   end

   assign shaped = shaped_ff;

endmodule
`default_nettype wire

/* rtl/pdz_gain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdz_gain: gain products, shift and force bias
// Stage C forms both 16x16 products; stage D combines, shifts and biases.
// ----------------------------------------------------------------------------
module pdz_gain (
   input  wire logic                clock,
   input  wire logic                en_c,
   input  wire logic                en_d,
   input  wire pdz_pkg::cfg_type    cfg,
   input  wire pdz_pkg::shaped_type shaped,
   output pdz_pkg::drive_type       drive
);
   import pdz_pkg::*;

   logic signed [31:0] prop_ff, prop_in;
   logic signed [31:0] diff_ff, diff_in;
   logic               idle_ff, up_ff, up_in, dn_ff, dn_in;
   side_type           side_ff;
   drive_type          drive_ff, drive_in;

   // Stage C: products and crawl direction
   always_comb begin
      logic signed [15:0] dz16;
      dz16    = $signed({1'b0, cfg.dead_zone});
      prop_in = shaped.err * cfg.prop_gain;
      if (cfg.use_rate) begin
         diff_in = shaped.side.rate * cfg.diff_gain;
      end else begin
         diff_in = 32'sd0;
      end
      up_in = shaped.err > dz16;
      dn_in = shaped.err < -dz16;
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         prop_ff <= prop_in;
         diff_ff <= diff_in;
         idle_ff <= shaped.idle;
         up_ff   <= up_in;
         dn_ff   <= dn_in;
         side_ff <= shaped.side;
      end
   end

   // Stage D: difference, floor shift, bias
   always_comb begin
      logic signed [32:0] sum;
      logic signed [32:0] shifted;
      logic signed [33:0] bias34;
      sum     = $signed({prop_ff[31], prop_ff}) - $signed({diff_ff[31], diff_ff});
      shifted = sum >>> cfg.control_shift;
      if (cfg.use_force) begin
         bias34 = $signed({{18{side_ff.bias[15]}}, side_ff.bias});
      end else begin
         bias34 = 34'sd0;
      end
      drive_in.value    = $signed({shifted[32], shifted}) + bias34;
      drive_in.idle     = idle_ff;
      drive_in.crawl_up = up_ff;
      drive_in.crawl_dn = dn_ff;
      drive_in.side     = side_ff;
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule
`default_nettype wire

/* rtl/pdz_limit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdz_limit: saturation, crawl and idle selection
// Stage E limits the drive, applies crawl speed and registers the result.
// ----------------------------------------------------------------------------
module pdz_limit (
   input  wire logic               clock,
   input  wire logic               en_e,
   input  wire pdz_pkg::cfg_type   cfg,
   input  wire pdz_pkg::drive_type drive,
   output logic signed [15:0]      result
);
   import pdz_pkg::*;

   logic signed [15:0] result_ff, result_in;

   always_comb begin
      logic signed [33:0] hi34;
      logic signed [33:0] lo34;
      logic signed [33:0] sat;
      logic        [15:0] crawl16;
      hi34    = $signed({{18{drive.side.hi[15]}}, drive.side.hi});
      lo34    = $signed({{18{drive.side.lo[15]}}, drive.side.lo});
      crawl16 = {1'b0, cfg.crawl_speed};
      sat     = drive.value;
      // upper limit first, so an inverted pair resolves to the lower limit
      if (sat > hi34) begin
         sat = hi34;
      end
      if (sat < lo34) begin
         sat = lo34;
      end
      result_in = sat[15:0];
      if (drive.idle) begin
         result_in = cfg.use_force ? drive.side.bias : 16'sd0;
      end else if (sat == 34'sd0 && cfg.crawl_speed != 15'd0) begin
         if (drive.crawl_up) begin
            result_in = $signed(crawl16);
         end else if (drive.crawl_dn) begin
            result_in = $signed(16'd0 - crawl16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

/* rtl/pd_positioner_dead_zone.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pd_positioner_dead_zone: PD position controller with dead zone
// Usage: software sets the control registers through the csr_ port while no
// word is in flight (plain writes: csr_wr_en, csr_index, csr_wdata; no read
// back). Each req_ word carries target and measured position, rate, force
// bias and the drive limits; each accepted word yields one rsp_ word with the
// drive value, in order.
// Both channels move a word at an edge where valid is high and stall is low.
// Pipeline: a word accepted on req_ passes through five register stages
// (error, shaping, products, shift and bias, limit) before it reaches rsp_.
// Throughput: one word per cycle while rsp_stall is low; holds up to five words.
// Stall: each stage advances when it is empty or the stage after it moves,
// so bubbles squeeze out; req_stall rises only when all five stages are
// full and the receiver stalls. Nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults (max_error = 0.9 in Q15, all others zero).
// ----------------------------------------------------------------------------
module pd_positioner_dead_zone (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [pdz_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pdz_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [31:0]                req_target_pos,
   input  wire logic signed [31:0]                req_measured_pos,
   input  wire logic signed [15:0]                req_measured_rate,
   input  wire logic signed [15:0]                req_force_bias,
   input  wire logic signed [15:0]                req_drive_min,
   input  wire logic signed [15:0]                req_drive_max,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [15:0]                     rsp_drive
);
   import pdz_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic       en_a, en_b, en_c, en_d, en_e;
   side_type   side_in;
   shaped_type shaped;
   drive_type  drive;

   // Control registers: hold unless written
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEAD_ZONE:     cfg_in.dead_zone     = csr_wdata[14:0];
            CSR_CRAWL_SPEED:   cfg_in.crawl_speed   = csr_wdata[14:0];
            CSR_PROP_GAIN:     cfg_in.prop_gain     = $signed(csr_wdata);
            CSR_DIFF_GAIN:     cfg_in.diff_gain     = $signed(csr_wdata);
            CSR_CONTROL_SHIFT: cfg_in.control_shift = csr_wdata[4:0];
            CSR_MAX_ERROR:     cfg_in.max_error     = csr_wdata[14:0];
            CSR_USE_RATE:      cfg_in.use_rate      = csr_wdata[0];
            CSR_USE_FORCE:     cfg_in.use_force     = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone     <= '0;
         cfg_ff.crawl_speed   <= '0;
         cfg_ff.prop_gain     <= '0;
         cfg_ff.diff_gain     <= '0;
         cfg_ff.control_shift <= '0;
         cfg_ff.max_error     <= MAX_ERROR_RESET;
         cfg_ff.use_rate      <= 1'b0;
         cfg_ff.use_force     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance a stage when it is empty or its successor moves
   assign en_e = !ve_ff || !rsp_stall;
   assign en_d = !vd_ff || en_e;
   assign en_c = !vc_ff || en_d;
   assign en_b = !vb_ff || en_c;
   assign en_a = !va_ff || en_b;

   assign req_stall = !en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= req_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
         if (en_d) begin
            vd_ff <= vc_ff;
         end
         if (en_e) begin
            ve_ff <= vd_ff;
         end
      end
   end

   assign side_in.rate = req_measured_rate;
   assign side_in.bias = req_force_bias;
   assign side_in.lo   = req_drive_min;
   assign side_in.hi   = req_drive_max;

   pdz_error u_error (
      .clock        (clock),
      .en_a         (en_a),
      .en_b         (en_b),
      .cfg          (cfg_ff),
      .target_pos   (req_target_pos),
      .measured_pos (req_measured_pos),
      .side_in      (side_in),
      .shaped       (shaped)
   );

   pdz_gain u_gain (
      .clock  (clock),
      .en_c   (en_c),
      .en_d   (en_d),
      .cfg    (cfg_ff),
      .shaped (shaped),
      .drive  (drive)
   );

   pdz_limit u_limit (
      .clock  (clock),
      .en_e   (en_e),
      .cfg    (cfg_ff),
      .drive  (drive),
      .result (rsp_drive)
   );

   assign rsp_valid = ve_ff;

   // Input stalls only with every stage full and the receiver stalling
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (va_ff && vb_ff && vc_ff && vd_ff && ve_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // Reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // A word in the shift and bias stage moves to the output stage when it advances
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && en_e) |=> rsp_valid)
      else $error("word lost between limit stage and output");

endmodule
`default_nettype wire

/* verif/tb_pd_positioner_dead_zone.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_pd_positioner_dead_zone: self-checking bench for the dead-zone PD stage
// Drives position words through the req_ channel and checks every rsp_ word
// against a predictor of the control law. The predictor uses a shadow copy of
// the control registers. Directed words hit the dead-zone edges, the error
// clamp, crawl and limit corner cases. Random words under random register
// settings follow, with random gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_pd_positioner_dead_zone;
   timeunit 1ns;
   timeprecision 1ps;

   import pdz_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   // One position word as it enters the block
   typedef struct packed {
      logic signed [31:0] target_pos;
      logic signed [31:0] measured_pos;
      logic signed [15:0] measured_rate;
      logic signed [15:0] force_bias;
      logic signed [15:0] drive_min;
      logic signed [15:0] drive_max;
   } pos_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [31:0]     req_target_pos = '0;
   logic signed [31:0]     req_measured_pos = '0;
   logic signed [15:0]     req_measured_rate = '0;
   logic signed [15:0]     req_force_bias = '0;
   logic signed [15:0]     req_drive_min = '0;
   logic signed [15:0]     req_drive_max = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [15:0]     rsp_drive;

   // Shadow of the control registers, kept in step with every csr_ write
   cfg_type                shadow_cfg;
   // Drive values still owed by the block, oldest first
   logic signed [15:0]     drive_q[$];

   int                     mismatches = 0;
   int                     words_sent = 0;
   int                     words_checked = 0;
   int                     csr_writes = 0;
   int                     quiet_cycles = 0;
   int                     stall_run = 0;
   bit                     gaps_on = 1'b1;
   bit                     stalls_on = 1'b1;

   pd_positioner_dead_zone dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_target_pos    (req_target_pos),
      .req_measured_pos  (req_measured_pos),
      .req_measured_rate (req_measured_rate),
      .req_force_bias    (req_force_bias),
      .req_drive_min     (req_drive_min),
      .req_drive_max     (req_drive_max),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive         (rsp_drive)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Control law: error, dead zone, clamp, PD sum, shift, bias, limits, crawl.
   // Everything is held in 64 bits so nothing wraps.
   function automatic logic signed [15:0] predict_drive(input cfg_type c,
                                                        input pos_word_type w);
      longint err, dz, me, crawl, bias, lo, hi, idle_drive, v;
      dz    = c.dead_zone;
      me    = c.max_error;
      crawl = c.crawl_speed;
      bias  = longint'($signed(w.force_bias));
      lo    = longint'($signed(w.drive_min));
      hi    = longint'($signed(w.drive_max));
      idle_drive = c.use_force ? bias : 0;
      err = longint'($signed(w.target_pos)) - longint'($signed(w.measured_pos));
      if (err == 0)
         return idle_drive[15:0];
      // positive side: clamp, or pull toward zero when crawl is off
      if (err > dz) begin
         if (err > me)
            err = me;
         else if (crawl == 0)
            err -= dz;
      end else if (err > 0) begin
         return idle_drive[15:0];
      end
      // negative side, mirrored
      if (err < -dz) begin
         if (err < -me)
            err = -me;
         else if (crawl == 0)
            err += dz;
      end else if (err < 0) begin
         return idle_drive[15:0];
      end
      v = err * longint'($signed(c.prop_gain));
      if (c.use_rate)
         v -= longint'($signed(w.measured_rate)) * longint'($signed(c.diff_gain));
      // arithmetic shift: rounds toward minus infinity
      v = v >>> c.control_shift;
      if (c.use_force)
         v += bias;
      // upper limit first, so an inverted pair leaves drive_min in force
      if (v > hi)
         v = hi;
      if (v < lo)
         v = lo;
      // crawl replaces a zero drive, even outside the limits
      if (v == 0 && crawl > 0) begin
         if (err > dz)
            v = crawl;
         else if (err < -dz)
            v = -crawl;
      end
      return v[15:0];
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic pos_word_type make_word(input logic signed [31:0] tgt,
                                              input logic signed [31:0] meas,
                                              input logic signed [15:0] rate,
                                              input logic signed [15:0] bias,
                                              input logic signed [15:0] lo,
                                              input logic signed [15:0] hi);
      pos_word_type w;
      w.target_pos    = tgt;
      w.measured_pos  = meas;
      w.measured_rate = rate;
      w.force_bias    = bias;
      w.drive_min     = lo;
      w.drive_max     = hi;
      return w;
   endfunction

   // Random word; the error is steered toward the dead-zone and clamp edges
   function automatic pos_word_type rand_word(input cfg_type c);
      pos_word_type       w;
      int                 kind;
      longint             mag;
      logic [31:0]        delta;
      logic signed [15:0] a, b;
      w.target_pos = $urandom;
      kind = $urandom_range(0, 5);
      case (kind)
         0: mag = 0;
         1: mag = longint'(c.dead_zone) + $urandom_range(0, 2) - 1;
         2: mag = longint'(c.max_error) + $urandom_range(0, 2) - 1;
         3: mag = $urandom_range(0, 2 * (int'(c.dead_zone) + int'(c.max_error)) + 4);
         default: mag = 0;
      endcase
      if (kind >= 4) begin
         w.measured_pos = $urandom;
      end else begin
         delta = mag[31:0];
         if ($urandom_range(0, 1))
            delta = -delta;
         w.measured_pos = w.target_pos - delta;
      end
      if ($urandom_range(0, 3) == 0)
         w.measured_rate = 16'(int'($urandom_range(0, 40)) - 20);
      else
         w.measured_rate = 16'($urandom);
      if ($urandom_range(0, 3) == 0)
         w.force_bias = 16'(int'($urandom_range(0, 40)) - 20);
      else
         w.force_bias = 16'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            w.drive_min = 16'sh8000;
            w.drive_max = 16'sh7FFF;
         end
         4, 5, 6: begin
            w.drive_min = 16'(-int'($urandom_range(0, 200)));
            w.drive_max = 16'($urandom_range(0, 200));
         end
         7, 8: begin
            a = 16'($urandom);
            b = 16'($urandom);
            w.drive_min = (a < b) ? a : b;
            w.drive_max = (a < b) ? b : a;
         end
         default: begin
            // either order, inverted pairs included
            w.drive_min = 16'($urandom);
            w.drive_max = 16'($urandom);
         end
      endcase
      return w;
   endfunction

   // Register value: an extreme, a small value or any 16 bits
   function automatic logic [15:0] pick_csr(input logic [15:0] low_v,
                                            input logic [15:0] high_v);
      case ($urandom_range(0, 7))
         0: return low_v;
         1: return high_v;
         2, 3: return 16'($urandom_range(0, 600));
         4: return 16'(-int'($urandom_range(1, 600)));
         default: return 16'($urandom);
      endcase
   endfunction

   // Write one register at the next edge and mirror it in the shadow copy
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_DEAD_ZONE:     shadow_cfg.dead_zone     = data[14:0];
         CSR_CRAWL_SPEED:   shadow_cfg.crawl_speed   = data[14:0];
         CSR_PROP_GAIN:     shadow_cfg.prop_gain     = data;
         CSR_DIFF_GAIN:     shadow_cfg.diff_gain     = data;
         CSR_CONTROL_SHIFT: shadow_cfg.control_shift = data[4:0];
         CSR_MAX_ERROR:     shadow_cfg.max_error     = data[14:0];
         CSR_USE_RATE:      shadow_cfg.use_rate      = data[0];
         CSR_USE_FORCE:     shadow_cfg.use_force     = data[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic write_all(input logic [15:0] dz, input logic [15:0] crawl,
                            input logic [15:0] pg, input logic [15:0] dg,
                            input logic [15:0] sh, input logic [15:0] me,
                            input logic [15:0] ur, input logic [15:0] uf);
      write_csr(CSR_DEAD_ZONE, dz);
      write_csr(CSR_CRAWL_SPEED, crawl);
      write_csr(CSR_PROP_GAIN, pg);
      write_csr(CSR_DIFF_GAIN, dg);
      write_csr(CSR_CONTROL_SHIFT, sh);
      write_csr(CSR_MAX_ERROR, me);
      write_csr(CSR_USE_RATE, ur);
      write_csr(CSR_USE_FORCE, uf);
   endtask

   task automatic write_random_settings();
      write_all(pick_csr(16'd0, 16'd32767), pick_csr(16'd0, 16'd32767),
                pick_csr(16'h8000, 16'h7FFF), pick_csr(16'h8000, 16'h7FFF),
                pick_csr(16'd0, 16'd31), pick_csr(16'd0, 16'd32767),
                pick_csr(16'd0, 16'd1), pick_csr(16'd0, 16'd1));
   endtask

   // Present one word from a falling edge, hold it until accepted, then
   // drop valid for a random gap. Returns at a falling edge.
   task automatic send_word(input pos_word_type w);
      int gap;
      req_target_pos    = w.target_pos;
      req_measured_pos  = w.measured_pos;
      req_measured_rate = w.measured_rate;
      req_force_bias    = w.force_bias;
      req_drive_min     = w.drive_min;
      req_drive_max     = w.drive_max;
      req_valid         = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      drive_q.push_back(predict_drive(shadow_cfg, w));
      words_sent++;
      @(negedge clock);
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and hold off until every owed drive has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (drive_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_word(rand_word(shadow_cfg));
   endtask

   // ---------------------------------------------------------------- tests

   // Register defaults: zero gains, so every drive comes out zero
   task automatic test_reset_defaults();
      send_word(make_word(32'sd5000, -32'sd5000, 16'sd100, 16'sd77,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd1, 16'sd1,
                          -16'sd10, 16'sd10));
      send_word(make_word(32'sd3, 32'sd3, 16'sd0, -16'sd9, 16'sd0, 16'sd0));
      wait_drained();
   endtask

   // Dead-zone edges, clamp, full-range errors, inverted limits, floor shift
   task automatic test_dead_zone_and_clamp();
      write_all(16'd100, 16'd0, 16'd300, -16'd7, 16'd3, 16'd2000, 16'd1, 16'd1);
      // zero error and both edges of the dead zone pass the bias
      send_word(make_word(32'sd1000, 32'sd1000, 16'sd5, -16'sd1234,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sd1100, 32'sd1000, 16'sd5, 16'sd321,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sd900, 32'sd1000, 16'sd5, 16'sd321,
                          16'sh8000, 16'sh7FFF));
      // one step outside on each side
      send_word(make_word(32'sd1101, 32'sd1000, 16'sd9, 16'sd0,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sd899, 32'sd1000, -16'sd9, 16'sd0,
                          16'sh8000, 16'sh7FFF));
      // widest errors both ways with extreme rate and bias
      send_word(make_word(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000, 16'sh7FFF,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000,
                          16'sh8000, 16'sh7FFF));
      // inverted limits: drive_min wins
      send_word(make_word(32'sd500, 32'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100));
      // saturate at the upper rail
      send_word(make_word(32'sd2500, 32'sd0, 16'sh8000, 16'sd0,
                          -16'sd50, 16'sd50));
      // negative product with odd low bits: floor on the shift
      send_word(make_word(32'sd0, 32'sd107, 16'sd0, 16'sd0,
                          16'sh8000, 16'sh7FFF));
      wait_drained();
   endtask

   // Clamp to a value inside the dead zone gives no crawl
   task automatic test_clamp_inside_dead_zone();
      write_all(16'd50, 16'd7, 16'd0, 16'd0, 16'd0, 16'd30, 16'd0, 16'd0);
      send_word(make_word(32'sd60, 32'sd0, 16'sd0, 16'sd0, -16'sd5, 16'sd5));
      send_word(make_word(-32'sd60, 32'sd0, 16'sd0, 16'sd0, -16'sd5, 16'sd5));
      send_word(make_word(32'sd40, 32'sd0, 16'sd0, 16'sd0, -16'sd5, 16'sd5));
      wait_drained();
   endtask

   // Crawl replaces a zero drive, also outside the limits
   task automatic test_crawl();
      write_all(16'd10, 16'd1000, -16'd1, 16'd0, 16'd8, 16'd32767, 16'd0, 16'd0);
      send_word(make_word(32'sd0, 32'sd20, 16'sd0, 16'sd0, -16'sd3, 16'sd3));
      send_word(make_word(32'sd20, 32'sd0, 16'sd0, 16'sd0, -16'sd3, 16'sd3));
      send_word(make_word(32'sd0, 32'sd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
      send_word(make_word(32'sd11, 32'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd9));
      wait_drained();
   endtask

   // Every register at its low and then its high extreme
   task automatic test_register_extremes();
      write_all(16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);
      send_word(make_word(32'sd1, 32'sd0, 16'sh7FFF, 16'sh7FFF,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'sh7FFF));
      wait_drained();
      write_all(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF);
      send_word(make_word(32'sd32767, 32'sd0, 16'sh8000, 16'sh7FFF,
                          16'sh8000, 16'sh7FFF));
      send_word(make_word(32'sd0, 32'sd32768, 16'sh7FFF, 16'sh8000,
                          -16'sd4, 16'sd4));
      wait_drained();
   endtask

   // Full rate with no gaps and no receiver stalls
   task automatic test_back_to_back();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_random_settings();
      send_random(60);
      wait_drained();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // Sender holds off mid-stream until the pipeline is empty
   task automatic test_drain_pause();
      write_random_settings();
      send_random(20);
      wait_drained();
      send_random(20);
      wait_drained();
   endtask

   // Random words under a series of random settings
   task automatic test_random_settings();
      repeat (6) begin
         write_random_settings();
         send_random(112);
         wait_drained();
      end
   endtask

   // ------------------------------------------------------------- processes

   // Receiver: random stall runs, mostly short, sometimes long
   always @(negedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= stalls_on && ($urandom_range(0, 2) == 0);
         stall_run = pick_gap();
      end
   end

   // Check each accepted drive against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            $error("drive: nothing expected, actual %0d", rsp_drive);
            mismatches++;
         end else begin
            if (rsp_drive !== drive_q[0]) begin
               $error("drive: expected %0d, actual %0d", drive_q[0], rsp_drive);
               mismatches++;
            end
            void'(drive_q.pop_front());
            words_checked++;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_pd_positioner_dead_zone NOT OK");
         $finish;
      end
   end

   initial begin
      // register defaults as they come out of reset
      shadow_cfg               = '0;
      shadow_cfg.max_error     = MAX_ERROR_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_dead_zone_and_clamp();
      test_clamp_inside_dead_zone();
      test_crawl();
      test_register_extremes();
      test_back_to_back();
      test_drain_pause();
      test_random_settings();

      wait_drained();
      // let the five-stage pipeline run dry to catch stray words
      repeat (10) @(posedge clock);

      $display("summary: %0d words sent, %0d drives checked, %0d register writes",
               words_sent, words_checked, csr_writes);
      $display("summary: dead-zone edges, clamp, crawl, limits and random settings");
      if (mismatches == 0 && drive_q.size() == 0) begin
         $display("tb_pd_positioner_dead_zone OK");
      end else begin
         if (drive_q.size() != 0)
            $error("drive: %0d expected words never arrived", drive_q.size());
         $display("tb_pd_positioner_dead_zone NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
